// File: rtl/core/ccbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_pkg
// Shared types and constants for the centre-crop box downscaler.
// ----------------------------------------------------------------------------
package ccbd_pkg;

   localparam int DEF_MAX_SIDE = 4096;
   localparam int DEF_MAX_TILE = 256;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 13;
   localparam int SIZE_W     = 9;
   localparam int COORD_W    = 8;
   localparam int SUM_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SIZE     = 2'd2;

   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd256;
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd256;
   localparam logic [SIZE_W-1:0] RST_OUT_SIZE     = 9'd64;

   typedef struct packed {
      logic [PIX_W-1:0] gray_pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   tile_pixel;
      logic [COORD_W-1:0] tile_x;
      logic [COORD_W-1:0] tile_y;
      logic               tile_done;
      logic               size_error;
   } rsp_type;

endpackage

// File: rtl/core/center_crop_box_downscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_crop_box_downscale
// Centre-crops a raster grey image to a square and box-averages it to a tile.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  : one source pixel per transfer; frame_start marks the first pixel
//           and latches image_width, image_height and out_size from the CSRs.
//  rsp_*  : one tile pixel when the last pixel of its box arrives, or a single
//           size_error result on a frame_start with invalid geometry.
//  csr_*  : plain write port; write only while the block is idle.
// Sequencing: a pixel that closes no box passes S_PIX and S_ADV. A box-column
//  end adds the RAM read state S_COL and an edge division; a completed box adds
//  the mean division and the output state S_EMIT; a row end adds another edge
//  division. All divisions use the shared one-bit-per-cycle divider, and a
//  frame_start adds one extra division. No new pixel is taken until the last
//  one is through. A size error goes from S_IDLE straight to S_EMIT; every
//  result is presented from the output register.
// Column partial sums of the current band live in a MAX_TILE-entry RAM.
// Reset: synchronous; clears control state and loads the CSR defaults.
// Stall: a result waits in the output register; the next pixel is still
//  accepted, and the block holds only when a further result is ready.
// ----------------------------------------------------------------------------
module center_crop_box_downscale #(
   parameter int MAX_SIDE = ccbd_pkg::DEF_MAX_SIDE,
   parameter int MAX_TILE = ccbd_pkg::DEF_MAX_TILE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ccbd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ccbd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [ccbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccbd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int EDGE_W = SIDE_W + 1;
   localparam int K_W    = $clog2(MAX_TILE + 3);
   localparam int IDX_W  = $clog2(MAX_TILE);
   localparam int DEN_W  = 2 * SIDE_W;
   localparam int NUM_W  = K_W + SIDE_W;
   localparam int STEP_W = $clog2(ccbd_pkg::SUM_W + 1);
   localparam int SUM_W  = ccbd_pkg::SUM_W;

   typedef enum logic [3:0] {
      S_IDLE, S_EDGE1, S_PIX, S_COL, S_MEAN, S_CDIV, S_RDIV, S_ADV, S_EMIT
   } state_type;

   state_type state_ff;

   logic [ccbd_pkg::DIM_W-1:0]  reg_w_ff, reg_h_ff;
   logic [ccbd_pkg::SIZE_W-1:0] reg_size_ff;

   logic [ccbd_pkg::PIX_W-1:0]  pix_ff;
   logic [SIDE_W-1:0]           fw_ff, fh_ff, side_ff, x0_ff, y0_ff;
   logic [ccbd_pkg::SIZE_W-1:0] size_ff;
   logic                        active_ff, err_ff;
   logic [SIDE_W-1:0]           scol_ff, srow_ff, cx_ff, cy_ff;
   logic [K_W-1:0]              tcol_ff, trow_ff;
   logic [EDGE_W-1:0]           ncol_ff, nrow_ff, pcol_ff, prow_ff, edge1_ff;
   logic [SUM_W-1:0]            run_ff;
   logic                        have_res_ff;
   ccbd_pkg::rsp_type           res_ff;
   logic                        rsp_valid_ff;
   ccbd_pkg::rsp_type           rsp_data_ff;

   logic [SUM_W-1:0]  dq_ff;
   logic [DEN_W-1:0]  dr_ff, dd_ff;
   logic [STEP_W-1:0] dn_ff;

   logic [SUM_W-1:0]  mem_rdata;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_raddr;

   // frame set-up
   logic [ccbd_pkg::DIM_W-1:0] side_c;
   logic                       bad_c;

   // pixel evaluation
   logic              in_crop, first_c, rfirst_c, guard_c, colend_c, rowcond_c;
   logic [SIDE_W-1:0] cx_c, cy_c;
   logic [K_W-1:0]    tcol_e, trow_e;
   logic [EDGE_W-1:0] ncol_e, nrow_e, pcol_e, prow_e, cx1_c, cy1_c;
   logic [SUM_W-1:0]  run_b, run_n;

   // box end
   logic [SUM_W-1:0]    total_c;
   logic [2*EDGE_W-1:0] count_c;
   logic [DEN_W-1:0]    den_c;
   logic [EDGE_W-1:0]   ocx1, ocy1;
   logic                row_after_col;

   // divider step
   logic [DEN_W:0]    d_sh, d_diff;
   logic              d_ge;
   logic              accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      side_c = (reg_w_ff < reg_h_ff) ? reg_w_ff : reg_h_ff;
      bad_c  = (reg_w_ff == '0) || (reg_h_ff == '0) ||
               (32'(reg_w_ff) > 32'(MAX_SIDE)) || (32'(reg_h_ff) > 32'(MAX_SIDE)) ||
               (reg_size_ff == '0) || (32'(reg_size_ff) > 32'(MAX_TILE)) ||
               (32'(reg_size_ff) > 32'(side_c));

      in_crop = (scol_ff >= x0_ff) && (EDGE_W'(scol_ff) < EDGE_W'(x0_ff) + EDGE_W'(side_ff)) &&
                (srow_ff >= y0_ff) && (EDGE_W'(srow_ff) < EDGE_W'(y0_ff) + EDGE_W'(side_ff));
      cx_c     = scol_ff - x0_ff;
      cy_c     = srow_ff - y0_ff;
      cx1_c    = EDGE_W'(cx_c) + 1'b1;
      cy1_c    = EDGE_W'(cy_c) + 1'b1;
      first_c  = (cx_c == '0);
      rfirst_c = first_c && (cy_c == '0);
      tcol_e   = first_c  ? '0       : tcol_ff;
      ncol_e   = first_c  ? edge1_ff : ncol_ff;
      pcol_e   = first_c  ? '0       : pcol_ff;
      run_b    = first_c  ? '0       : run_ff;
      trow_e   = rfirst_c ? '0       : trow_ff;
      nrow_e   = rfirst_c ? edge1_ff : nrow_ff;
      prow_e   = rfirst_c ? '0       : prow_ff;
      guard_c  = (32'(tcol_e) >= 32'(size_ff)) || (32'(trow_e) >= 32'(size_ff));
      run_n    = run_b + SUM_W'(pix_ff);
      colend_c  = (cx1_c == ncol_e);
      rowcond_c = (cx1_c == EDGE_W'(side_ff)) && (cy1_c == nrow_e);
      mem_raddr = tcol_e[IDX_W-1:0];

      total_c = (EDGE_W'(cy_ff) == prow_ff) ? run_ff : (mem_rdata + run_ff);
      count_c = (2*EDGE_W)'(ncol_ff - pcol_ff) * (2*EDGE_W)'(nrow_ff - prow_ff);
      den_c   = (count_c == '0) ? DEN_W'(1) : DEN_W'(count_c);
      ocx1    = EDGE_W'(cx_ff) + 1'b1;
      ocy1    = EDGE_W'(cy_ff) + 1'b1;
      row_after_col = (ocx1 == EDGE_W'(side_ff)) && (ocy1 == nrow_ff);
      mem_we  = (state_ff == S_COL) && (ocy1 != nrow_ff);

      d_sh   = {dr_ff, dq_ff[SUM_W-1]};
      d_diff = d_sh - {1'b0, dd_ff};
      d_ge   = (d_sh >= {1'b0, dd_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reg_w_ff     <= ccbd_pkg::RST_IMAGE_WIDTH;
         reg_h_ff     <= ccbd_pkg::RST_IMAGE_HEIGHT;
         reg_size_ff  <= ccbd_pkg::RST_OUT_SIZE;
         active_ff    <= 1'b0;
         err_ff       <= 1'b0;
         have_res_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dn_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ccbd_pkg::CSR_IMAGE_WIDTH:  reg_w_ff    <= csr_wdata;
               ccbd_pkg::CSR_IMAGE_HEIGHT: reg_h_ff    <= csr_wdata;
               ccbd_pkg::CSR_OUT_SIZE:     reg_size_ff <= csr_wdata[ccbd_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         if (dn_ff != '0) begin
            dq_ff <= {dq_ff[SUM_W-2:0], d_ge};
            dr_ff <= d_ge ? d_diff[DEN_W-1:0] : d_sh[DEN_W-1:0];
            dn_ff <= dn_ff - 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pix_ff      <= req_data.gray_pixel;
                  have_res_ff <= req_data.frame_start && bad_c;
                  if (req_data.frame_start) begin
                     scol_ff <= '0;
                     srow_ff <= '0;
                     tcol_ff <= '0;
                     trow_ff <= '0;
                     ncol_ff <= '0;
                     nrow_ff <= '0;
                     run_ff  <= '0;
                     if (bad_c) begin
                        err_ff      <= 1'b1;
                        active_ff   <= 1'b0;
                        res_ff      <= '{tile_pixel: '0, tile_x: '0, tile_y: '0,
                                         tile_done: 1'b0, size_error: 1'b1};
                        state_ff    <= S_EMIT;
                     end else begin
                        err_ff    <= 1'b0;
                        active_ff <= 1'b1;
                        fw_ff     <= SIDE_W'(reg_w_ff);
                        fh_ff     <= SIDE_W'(reg_h_ff);
                        side_ff   <= SIDE_W'(side_c);
                        size_ff   <= reg_size_ff;
                        x0_ff     <= SIDE_W'((reg_w_ff - side_c) >> 1);
                        y0_ff     <= SIDE_W'((reg_h_ff - side_c) >> 1);
                        dq_ff     <= SUM_W'(side_c);
                        dr_ff     <= '0;
                        dd_ff     <= DEN_W'(reg_size_ff);
                        dn_ff     <= STEP_W'(SUM_W);
                        state_ff  <= S_EDGE1;
                     end
                  end else if (active_ff && !err_ff) begin
                     state_ff <= S_PIX;
                  end
               end
            end
            S_EDGE1: begin
               if (dn_ff == '0) begin
                  edge1_ff <= EDGE_W'(dq_ff);
                  state_ff <= S_PIX;
               end
            end
            S_PIX: begin
               if (!in_crop) begin
                  state_ff <= S_ADV;
               end else begin
                  cx_ff   <= cx_c;
                  cy_ff   <= cy_c;
                  tcol_ff <= tcol_e;
                  ncol_ff <= ncol_e;
                  pcol_ff <= pcol_e;
                  nrow_ff <= nrow_e;
                  if (!guard_c && !colend_c && rowcond_c) begin
                     trow_ff <= trow_e + 1'b1;
                     prow_ff <= nrow_e;
                  end else begin
                     trow_ff <= trow_e;
                     prow_ff <= prow_e;
                  end
                  if (guard_c) begin
                     run_ff   <= run_b;
                     state_ff <= S_ADV;
                  end else begin
                     run_ff <= run_n;
                     priority if (colend_c) begin
                        state_ff <= S_COL;
                     end else if (rowcond_c) begin
                        dq_ff    <= SUM_W'(NUM_W'(trow_e + 2'd2) * NUM_W'(side_ff));
                        dr_ff    <= '0;
                        dd_ff    <= DEN_W'(size_ff);
                        dn_ff    <= STEP_W'(SUM_W);
                        state_ff <= S_RDIV;
                     end else begin
                        state_ff <= S_ADV;
                     end
                  end
               end
            end
            S_COL: begin
               tcol_ff <= tcol_ff + 1'b1;
               pcol_ff <= ncol_ff;
               run_ff  <= '0;
               dr_ff   <= '0;
               dn_ff   <= STEP_W'(SUM_W);
               if (ocy1 == nrow_ff) begin
                  res_ff.tile_x     <= ccbd_pkg::COORD_W'(tcol_ff);
                  res_ff.tile_y     <= ccbd_pkg::COORD_W'(trow_ff);
                  res_ff.tile_done  <= (32'(tcol_ff) + 1 == 32'(size_ff)) &&
                                       (32'(trow_ff) + 1 == 32'(size_ff));
                  res_ff.size_error <= 1'b0;
                  dq_ff    <= total_c;
                  dd_ff    <= den_c;
                  state_ff <= S_MEAN;
               end else begin
                  dq_ff    <= SUM_W'(NUM_W'(tcol_ff + 2'd2) * NUM_W'(side_ff));
                  dd_ff    <= DEN_W'(size_ff);
                  state_ff <= S_CDIV;
               end
            end
            S_MEAN: begin
               if (dn_ff == '0) begin
                  res_ff.tile_pixel <= dq_ff[ccbd_pkg::PIX_W-1:0];
                  have_res_ff       <= 1'b1;
                  dq_ff    <= SUM_W'(NUM_W'(tcol_ff + 1'b1) * NUM_W'(side_ff));
                  dr_ff    <= '0;
                  dd_ff    <= DEN_W'(size_ff);
                  dn_ff    <= STEP_W'(SUM_W);
                  state_ff <= S_CDIV;
               end
            end
            S_CDIV: begin
               if (dn_ff == '0) begin
                  ncol_ff <= EDGE_W'(dq_ff);
                  if (row_after_col) begin
                     trow_ff  <= trow_ff + 1'b1;
                     prow_ff  <= nrow_ff;
                     dq_ff    <= SUM_W'(NUM_W'(trow_ff + 2'd2) * NUM_W'(side_ff));
                     dr_ff    <= '0;
                     dd_ff    <= DEN_W'(size_ff);
                     dn_ff    <= STEP_W'(SUM_W);
                     state_ff <= S_RDIV;
                  end else begin
                     state_ff <= S_ADV;
                  end
               end
            end
            S_RDIV: begin
               if (dn_ff == '0) begin
                  nrow_ff  <= EDGE_W'(dq_ff);
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               if (EDGE_W'(scol_ff) + 1'b1 >= EDGE_W'(fw_ff)) begin
                  scol_ff <= '0;
                  srow_ff <= srow_ff + 1'b1;
                  if (EDGE_W'(srow_ff) + 1'b1 >= EDGE_W'(fh_ff)) begin
                     active_ff <= 1'b0;
                  end
               end else begin
                  scol_ff <= scol_ff + 1'b1;
               end
               state_ff <= have_res_ff ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  have_res_ff  <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ccbd_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_TILE)
   ) u_band_sums (
      .clock(clock),
      .we   (mem_we),
      .waddr(tcol_ff[IDX_W-1:0]),
      .wdata(total_c),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   a_err_excl: assert property (@(posedge clock) disable iff (reset)
      !(active_ff && err_ff))
      else $error("active and error both set");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      (dn_ff != '0) |-> (state_ff == S_EDGE1 || state_ff == S_MEAN ||
                         state_ff == S_CDIV || state_ff == S_RDIV))
      else $error("divider running outside a division state");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MEAN && dn_ff == '0) |-> (dq_ff[SUM_W-1:ccbd_pkg::PIX_W] == '0))
      else $error("box mean above pixel range");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.size_error) |->
         (rsp_data_ff.tile_pixel == '0 && !rsp_data_ff.tile_done))
      else $error("error result carries pixel data");

endmodule

// File: rtl/core/ccbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: verif/center_crop_box_downscale_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_crop_box_downscale_tb
// Streams small grey images through the centre-crop box downscaler and checks
// every tile pixel and size error against a behavioural predictor. Covers
// portrait, landscape and square crops, size errors, early frame starts,
// excess pixels, random request gaps and random response stalls.
// ----------------------------------------------------------------------------
module center_crop_box_downscale_tb;

   localparam int NMAX_SIDE = 4096;
   localparam int NMAX_TILE = 256;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ccbd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ccbd_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [ccbd_pkg::CSR_IDX_W-1:0] csr_index = ccbd_pkg::CSR_IMAGE_WIDTH;
   logic [ccbd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   center_crop_box_downscale dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned cfg_w, cfg_h, cfg_size;
   int unsigned col_sums [NMAX_TILE];
   int unsigned box_sum, src_col, src_row, t_col, t_row, col_edge, row_edge;
   bit err_lat, frame_on;
   int unsigned f_w, f_h, f_side, f_x0, f_y0, f_size;

   ccbd_pkg::rsp_type tile_queue [$];
   int errors = 0;
   int n_items = 0, n_pixels = 0, n_size_err = 0;
   bit quiet = 1'b0;

   function automatic int unsigned box_edge(int unsigned k);
      return (k * f_side) / f_size;
   endfunction

   function automatic void predict_tile(ccbd_pkg::req_type it);
      int unsigned side, cx, cy, total, fc, fr, cnt;
      ccbd_pkg::rsp_type r;
      if (it.frame_start) begin
         side = cfg_w < cfg_h ? cfg_w : cfg_h;
         src_col = 0; src_row = 0; t_col = 0; t_row = 0;
         col_edge = 0; row_edge = 0; box_sum = 0;
         if (cfg_w == 0 || cfg_h == 0 || cfg_w > NMAX_SIDE || cfg_h > NMAX_SIDE ||
             cfg_size == 0 || cfg_size > NMAX_TILE || cfg_size > side) begin
            err_lat = 1; frame_on = 0;
            r = '0; r.size_error = 1'b1;
            tile_queue = {tile_queue, r};
            return;
         end
         err_lat = 0; frame_on = 1;
         f_w = cfg_w; f_h = cfg_h; f_side = side; f_size = cfg_size;
         f_x0 = (f_w - side) / 2; f_y0 = (f_h - side) / 2;
      end
      if (!frame_on || err_lat) return;
      if (src_col >= f_x0 && src_col < f_x0 + f_side &&
          src_row >= f_y0 && src_row < f_y0 + f_side) begin
         cx = src_col - f_x0; cy = src_row - f_y0;
         if (cx == 0) begin
            if (cy == 0) begin
               t_row = 0; row_edge = box_edge(1);
            end
            t_col = 0; col_edge = box_edge(1); box_sum = 0;
         end
         if (!(t_col >= f_size || t_col >= NMAX_TILE || t_row >= f_size)) begin
            box_sum += it.gray_pixel;
            if (cx + 1 == col_edge) begin
               fc = box_edge(t_col); fr = box_edge(t_row);
               total = (cy == fr) ? box_sum : col_sums[t_col] + box_sum;
               if (cy + 1 == row_edge) begin
                  cnt = (col_edge - fc) * (row_edge - fr);
                  if (cnt == 0) cnt = 1;
                  r.tile_pixel = 8'((total / cnt) & 8'hFF);
                  r.tile_x = 8'(t_col);
                  r.tile_y = 8'(t_row);
                  r.tile_done = (t_col + 1 == f_size && t_row + 1 == f_size);
                  r.size_error = 1'b0;
                  tile_queue = {tile_queue, r};
               end else begin
                  col_sums[t_col] = total;
               end
               box_sum = 0; t_col++; col_edge = box_edge(t_col + 1);
            end
            if (cx + 1 == f_side && cy + 1 == row_edge) begin
               t_row++; row_edge = box_edge(t_row + 1);
            end
         end
      end
      src_col++;
      if (src_col >= f_w) begin
         src_col = 0; src_row++;
         if (src_row >= f_h) frame_on = 0;
      end
   endfunction

   task automatic idle_burst();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic send_pixel(logic [7:0] pix, logic fs);
      idle_burst();
      req_data <= '{gray_pixel: pix, frame_start: fs};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tile(req_data);
      n_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (tile_queue.size() != 0 && guard < 2000000) begin
         @(negedge clock); guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [ccbd_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= ccbd_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      if (idx == ccbd_pkg::CSR_IMAGE_WIDTH) cfg_w = val & 13'h1FFF;
      else if (idx == ccbd_pkg::CSR_IMAGE_HEIGHT) cfg_h = val & 13'h1FFF;
      else cfg_size = val & 9'h1FF;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned s);
      wait_drained();
      write_csr(ccbd_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(ccbd_pkg::CSR_IMAGE_HEIGHT, h);
      write_csr(ccbd_pkg::CSR_OUT_SIZE, s);
      csr_we <= 1'b0;
   endtask

   // mode 0 random, 1 all zero, 2 all max
   task automatic send_frame(int unsigned npix, int mode);
      for (int unsigned i = 0; i < npix; i++)
         send_pixel(mode == 1 ? 8'h00 : mode == 2 ? 8'hFF : 8'($urandom), i == 0);
   endtask

   always @(posedge clock) begin
      ccbd_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tile_queue.size() == 0) begin
            $error("unexpected result %h", rsp_data); errors++;
         end else begin
            exp_r = tile_queue.pop_front();
            if (exp_r.size_error) n_size_err++; else n_pixels++;
            if (rsp_data.tile_pixel !== exp_r.tile_pixel) begin
               $error("tile_pixel exp %0d got %0d", exp_r.tile_pixel, rsp_data.tile_pixel);
               errors++;
            end
            if (rsp_data.tile_x !== exp_r.tile_x) begin
               $error("tile_x exp %0d got %0d", exp_r.tile_x, rsp_data.tile_x); errors++;
            end
            if (rsp_data.tile_y !== exp_r.tile_y) begin
               $error("tile_y exp %0d got %0d", exp_r.tile_y, rsp_data.tile_y); errors++;
            end
            if (rsp_data.tile_done !== exp_r.tile_done) begin
               $error("tile_done exp %0d got %0d", exp_r.tile_done, rsp_data.tile_done);
               errors++;
            end
            if (rsp_data.size_error !== exp_r.size_error) begin
               $error("size_error exp %0d got %0d", exp_r.size_error, rsp_data.size_error);
               errors++;
            end
         end
      end
   end

   // receiver stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_no_frame();
      send_pixel(8'h5A, 1'b0);
      send_pixel(8'hA5, 1'b0);
   endtask

   task automatic test_extremes();
      set_geometry(4, 4, 1);
      send_frame(16, 2);
      set_geometry(4, 4, 4);
      send_frame(16, 1);
   endtask

   task automatic test_size_errors();
      set_geometry(3, 5, 4);
      send_pixel(8'h11, 1'b1); send_pixel(8'h22, 1'b0);
      set_geometry(0, 5, 1);
      send_pixel(8'h33, 1'b1);
      set_geometry(4097, 8191, 1);
      send_pixel(8'h44, 1'b1);
      set_geometry(300, 300, 257);
      send_pixel(8'h55, 1'b1);
      set_geometry(2, 2, 0);
      send_pixel(8'h66, 1'b1);
   endtask

   task automatic test_crop_shapes();
      set_geometry(7, 3, 2);
      send_frame(21, 0);
      set_geometry(2, 6, 2);
      send_frame(23, 0);   // includes excess pixels
      set_geometry(1, 1, 1);
      send_frame(1, 0);
   endtask

   task automatic test_early_start();
      set_geometry(5, 5, 3);
      send_frame(12, 0);
      send_frame(25, 0);
   endtask

   task automatic test_large_tile();
      set_geometry(4096, 256, 256);
      send_pixel(8'h80, 1'b1);
      for (int i = 0; i < 40; i++) send_pixel(8'($urandom), 1'b0);
      set_geometry(256, 2, 2);
      send_frame(512, 0);
   endtask

   task automatic test_random_frames();
      int unsigned w, h, s, side, npix;
      int r;
      while (n_items < 1400) begin
         w = $urandom_range(1, 12); h = $urandom_range(1, 12);
         side = w < h ? w : h;
         r = $urandom_range(0, 9);
         s = (r == 0) ? side + $urandom_range(1, 3) : $urandom_range(1, side);
         if (n_items > 1150) quiet = 1'b1;
         set_geometry(w, h, s);
         npix = w * h;
         r = $urandom_range(0, 9);
         if (r == 0) npix = $urandom_range(1, npix);
         else if (r == 1) npix = npix + $urandom_range(1, 5);
         send_frame(npix, 0);
         if ($urandom_range(0, 9) == 0) begin
            send_pixel(8'($urandom), 1'b0);
            send_frame(npix, 0);
         end
      end
   endtask

   initial begin
      cfg_w = ccbd_pkg::RST_IMAGE_WIDTH;
      cfg_h = ccbd_pkg::RST_IMAGE_HEIGHT;
      cfg_size = ccbd_pkg::RST_OUT_SIZE;
      box_sum = 0; src_col = 0; src_row = 0; t_col = 0; t_row = 0;
      col_edge = 0; row_edge = 0; err_lat = 0; frame_on = 0;
      f_w = 0; f_h = 0; f_side = 0; f_x0 = 0; f_y0 = 0; f_size = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      test_no_frame();
      test_extremes();
      test_size_errors();
      test_crop_shapes();
      test_early_start();
      test_large_tile();
      test_random_frames();
      wait_drained();
      $display("Sent %0d pixels; checked %0d tile pixels and %0d size errors.",
               n_items, n_pixels, n_size_err);
      if (errors == 0 && tile_queue.size() == 0)
         $display("[center_crop_box_downscale] OK");
      else
         $display("[center_crop_box_downscale] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[center_crop_box_downscale] ERROR");
      $finish;
   end

endmodule

// File: center_crop_box_downscale.f
rtl/core/ccbd_pkg.sv
rtl/core/ccbd_ram.sv
rtl/core/center_crop_box_downscale.sv
verif/center_crop_box_downscale_tb.sv
